/* rtl/core/wsd_pkg.sv */
// Package for the WebSocket frame deframer: parser phases, result record
// and header constants. No dependencies.
package wsd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 64;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned HBL_W  = 4;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extended-length and key byte counts
  localparam logic [HBL_W-1:0] HBL_EXT16 = 4'd2;
  localparam logic [HBL_W-1:0] HBL_EXT64 = 4'd8;
  localparam logic [HBL_W-1:0] HBL_KEY   = 4'd4;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef struct packed {
    logic              fin_flag;
    logic [3:0]        frame_kind;
    logic              was_masked;
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_valid;
    logic              last_of_frame;
  } res_t;

endpackage

/* rtl/core/wsd_in_stage.sv */
// Input register with skid entry for the deframer byte stream.
// Depends on wsd_pkg.
module wsd_in_stage import wsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              pop_i,
  output logic              main_valid_o,
  output logic [BYTE_W-1:0] main_byte_o
);

  logic              main_v_q, main_v_d;
  logic              skid_v_q, skid_v_d;
  logic [BYTE_W-1:0] main_q, main_d;
  logic [BYTE_W-1:0] skid_q, skid_d;
  logic              push;
  logic              pop;

  // ready is registered: only the skid entry being full holds off the sender
  assign in_ready_o   = !skid_v_q;
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && main_v_q;
  assign main_valid_o = main_v_q;
  assign main_byte_o  = main_q;

  // next state of the two entries
  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = push;
        main_d   = in_byte_i;
      end
    end else if (push) begin
      if (!main_v_q) begin
        main_v_d = 1'b1;
        main_d   = in_byte_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = in_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

/* rtl/core/wsd_parser.sv */
// Frame header parser and payload unmasker: one byte per step.
// Depends on wsd_pkg.
module wsd_parser import wsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  phase_e            phase_q, phase_d;
  logic              fin_q, fin_d;
  logic [3:0]        op_q, op_d;
  logic              mask_q, mask_d;
  logic [HBL_W-1:0]  hbl_q, hbl_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [1:0]        kpos_q, kpos_d;

  logic              go_after;
  logic              go_done;
  logic [LEN_W-1:0]  done_rem;
  logic [6:0]        len7;
  logic [BYTE_W-1:0] kb;
  logic              emit;
  logic [BYTE_W-1:0] emit_data;
  logic              emit_valid;
  logic              emit_last;

  assign len7 = byte_i[6:0];

  // key byte for this payload position, first key byte first
  always_comb begin
    case (kpos_q)
      2'd0:    kb = key_q[31:24];
      2'd1:    kb = key_q[23:16];
      2'd2:    kb = key_q[15:8];
      default: kb = key_q[7:0];
    endcase
  end

  // next state and result for the current byte
  always_comb begin
    phase_d    = phase_q;
    fin_d      = fin_q;
    op_d       = op_q;
    mask_d     = mask_q;
    hbl_d      = hbl_q;
    rem_d      = rem_q;
    key_d      = key_q;
    kpos_d     = kpos_q;
    go_after   = 1'b0;
    go_done    = 1'b0;
    done_rem   = rem_q;
    emit       = 1'b0;
    emit_data  = '0;
    emit_valid = 1'b0;
    emit_last  = 1'b0;

    unique case (phase_q)
      PH_LENGTH: begin
        mask_d = byte_i[7];
        key_d  = '0;
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          hbl_d   = (len7 == LEN_EXT16) ? HBL_EXT16 : HBL_EXT64;
          rem_d   = '0;
          phase_d = PH_EXTLEN;
        end else begin
          rem_d    = {{(LEN_W-7){1'b0}}, len7};
          go_after = 1'b1;
        end
      end
      PH_EXTLEN: begin
        rem_d = {rem_q[LEN_W-BYTE_W-1:0], byte_i};
        hbl_d = hbl_q - 1'b1;
        if (hbl_d == '0) go_after = 1'b1;
      end
      PH_KEY: begin
        key_d = {key_q[KEY_W-BYTE_W-1:0], byte_i};
        hbl_d = hbl_q - 1'b1;
        if (hbl_d == '0) go_done = 1'b1;
      end
      PH_PAYLOAD: begin
        kpos_d     = kpos_q + 1'b1;
        rem_d      = rem_q - 1'b1;
        emit       = 1'b1;
        emit_data  = mask_q ? (byte_i ^ kb) : byte_i;
        emit_valid = 1'b1;
        if (rem_d == '0) begin
          emit_last = 1'b1;
          phase_d   = PH_FIRST;
        end
      end
      default: begin
        fin_d   = byte_i[7];
        op_d    = byte_i[3:0];
        phase_d = PH_LENGTH;
      end
    endcase

    // length known: fetch key if masked
    if (go_after) begin
      if (mask_d) begin
        hbl_d   = HBL_KEY;
        key_d   = '0;
        phase_d = PH_KEY;
      end else begin
        go_done = 1'b1;
      end
    end

    // header complete: empty frame marker or start of payload
    done_rem = rem_d;
    if (go_done) begin
      if (done_rem == '0) begin
        phase_d   = PH_FIRST;
        emit      = 1'b1;
        emit_last = 1'b1;
      end else begin
        kpos_d  = '0;
        phase_d = PH_PAYLOAD;
      end
    end
  end

  assign res_valid_o          = step_i && emit;
  assign res_o.fin_flag       = fin_q;
  assign res_o.frame_kind     = op_q;
  assign res_o.was_masked     = mask_d;
  assign res_o.payload_byte   = emit_data;
  assign res_o.byte_valid     = emit_valid;
  assign res_o.last_of_frame  = emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      fin_q   <= 1'b0;
      op_q    <= '0;
      mask_q  <= 1'b0;
      hbl_q   <= '0;
      rem_q   <= '0;
      key_q   <= '0;
      kpos_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      hbl_q   <= hbl_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      kpos_q  <= kpos_d;
    end
  end

`ifndef ASSERT_OFF
  // payload phase always has bytes still due
  a_payload_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != '0)
    else $error("payload phase with zero remaining count");

  // key phase counts down from four
  a_key_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_KEY |-> (hbl_q != '0 && hbl_q <= HBL_KEY))
    else $error("key byte count out of range");

  // extended length counts down from two or eight
  a_ext_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_EXTLEN |-> (hbl_q != '0 && hbl_q <= HBL_EXT64))
    else $error("extended length byte count out of range");

  // an empty frame marker always closes its frame
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.byte_valid) |-> (res_o.last_of_frame && res_o.payload_byte == '0))
    else $error("empty frame marker without last mark");
`endif

endmodule

/* rtl/core/wsd_out_reg.sv */
// Result register for the deframer output channel.
// Depends on wsd_pkg.
module wsd_out_reg import wsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic can_take_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // free when empty or when the held result transfers this cycle
  assign can_take_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

endmodule

/* rtl/core/websocket_frame_deframer_core.sv */
// WebSocket frame deframer: parses back-to-back frames and unmasks payload.
// Channels: in (one raw stream byte per transfer), out (one result per transfer).
// A result carries FIN, opcode, mask flag, the unmasked byte, a data-valid flag
// and a last-of-frame mark. Header bytes give no result; a zero-length frame
// gives one marker result with byte_valid low on its last header byte.
// An accepted byte is first registered in the input stage, then passes the
// parser into the result register.
// Throughput: one byte per cycle while the result register is free; the parser
// step's longest path is the 64-bit payload count decrement and zero compare.
// in_ready_o comes from a register: the input stage holds one byte plus a
// skid byte, so ready drops only once both are taken.
// When the receiver stalls, the result register holds; the parser stops and
// the input stage fills, after which in_ready_o goes low.
// Reset (rst_ni low, asynchronous) empties both stages and returns the parser
// to expecting the first header byte of a frame.
// Depends on wsd_pkg, wsd_in_stage, wsd_parser and wsd_out_reg.
module websocket_frame_deframer_core import wsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              fin_flag_o,
  output logic [3:0]        frame_kind_o,
  output logic              was_masked_o,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic              byte_valid_o,
  output logic              last_of_frame_o
);

  logic              main_valid;
  logic [BYTE_W-1:0] main_byte;
  logic              can_take;
  logic              step;
  logic              res_valid;
  res_t              res;
  res_t              res_out;

  // a byte steps through the parser whenever the result register is free
  assign step = main_valid && can_take;

  wsd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .pop_i        (step),
    .main_valid_o (main_valid),
    .main_byte_o  (main_byte)
  );

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (main_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign fin_flag_o      = res_out.fin_flag;
  assign frame_kind_o    = res_out.frame_kind;
  assign was_masked_o    = res_out.was_masked;
  assign payload_byte_o  = res_out.payload_byte;
  assign byte_valid_o    = res_out.byte_valid;
  assign last_of_frame_o = res_out.last_of_frame;

endmodule
